// ===== src/rcs_pkg.sv =====
// Shared types and constants for the rod constraint state block.
`timescale 1ns / 1ps
package rcs_pkg;

    localparam int WORD_BITS  = 32;
    localparam int UNIT_BITS  = 30;
    localparam int MIN_BITS   = 16;
    localparam int DIFF_BITS  = WORD_BITS + 1;
    localparam int LEN_BITS   = WORD_BITS + 2;
    localparam int WIDE_BITS  = 2 * LEN_BITS;
    localparam int CNT_BITS   = 7;
    localparam int IN_BITS    = 8 * WORD_BITS;
    localparam int OUT_BITS   = 232;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_SHORT   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_CHECK,
        ST_DIVX,
        ST_DIVY,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_SAT,
        ST_CSQ,
        ST_CDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

// ===== src/rcs_serial_unit.sv =====
// Bit-serial multiply, restoring divide and square root unit.
`timescale 1ns / 1ps
module rcs_serial_unit
    import rcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  unit_req_t             req,
    input  logic [WIDE_BITS-1:0]  opa,
    input  logic [LEN_BITS-1:0]   opb,
    output unit_rsp_t             rsp,
    output logic [WIDE_BITS-1:0]  result
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    unit_op_t              op_reg, op_next;
    logic [WIDE_BITS-1:0]  acc_reg, acc_next;
    logic [WIDE_BITS-1:0]  aux_reg, aux_next;
    logic [LEN_BITS-1:0]   b_reg, b_next;
    logic [LEN_BITS+2:0]   rem_reg, rem_next;
    logic [LEN_BITS-1:0]   root_reg, root_next;
    logic [CNT_BITS-1:0]   last;
    logic [LEN_BITS+2:0]   div_try;
    logic [LEN_BITS+2:0]   sqrt_try;
    logic [LEN_BITS+2:0]   sqrt_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        aux_reg  <= aux_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        aux_next   = aux_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        div_try    = {1'b0, rem_reg[LEN_BITS:0], acc_reg[WIDE_BITS-1]};
        sqrt_try   = {rem_reg[LEN_BITS:0], acc_reg[WIDE_BITS-1 -: 2]};
        sqrt_trial = {1'b0, root_reg, 2'b01};
        unique case (op_reg)
            OP_MUL:  last = CNT_BITS'(LEN_BITS - 1);
            OP_DIV:  last = CNT_BITS'(WIDE_BITS - 1);
            OP_SQRT: last = CNT_BITS'(LEN_BITS - 1);
            default: last = CNT_BITS'(LEN_BITS - 1);
        endcase
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = req.op;
            acc_next  = (req.op == OP_MUL) ? '0 : opa;
            aux_next  = opa;
            b_next    = opb;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            unique case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + aux_reg;
                    end
                    aux_next = {aux_reg[WIDE_BITS-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[LEN_BITS-1:1]};
                end
                OP_DIV:
                begin
                    if (div_try >= {3'b000, b_reg})
                    begin
                        rem_next = div_try - {3'b000, b_reg};
                        acc_next = {acc_reg[WIDE_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = div_try;
                        acc_next = {acc_reg[WIDE_BITS-2:0], 1'b0};
                    end
                end
                OP_SQRT:
                begin
                    acc_next = {acc_reg[WIDE_BITS-3:0], 2'b00};
                    if (sqrt_try >= sqrt_trial)
                    begin
                        rem_next  = sqrt_try - sqrt_trial;
                        root_next = {root_reg[LEN_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = sqrt_try;
                        root_next = {root_reg[LEN_BITS-2:0], 1'b0};
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = (op_reg == OP_SQRT) ? {{(WIDE_BITS-LEN_BITS){1'b0}}, root_reg} : acc_reg;

endmodule

// ===== src/rod_constraint_state_top.sv =====
// Top level of the rod constraint state block: sequencer, state and stream ports.
`timescale 1ns / 1ps
// A full item runs two squares, a square root, three divides and five products, all
// on one bit-serial unit. An invalid pair goes straight to the output stage, and a
// too-short rod stops after the length check. One item is in work at a time; the
// output register lets the next item enter while a result waits. Reset clears the
// reference latch and sets min_length to 1.
module rod_constraint_state_top
    import rcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MIN_BITS-1:0]  cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pivot_x, pivot_y, bob_x, bob_y, pivot_vx, pivot_vy, bob_vx, bob_vy
    input  logic [IN_BITS-1:0]   s_tdata,
    // pair_valid
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rod_length, radial_x, radial_y, radial_speed, tangential_speed,
    // centripetal_term, length_error, zero fill
    output logic [OUT_BITS-1:0]  m_tdata,
    // status
    output logic [1:0]           m_tuser
);

    localparam logic [WORD_BITS-1:0] WMAX = {WORD_BITS{1'b1}};

    state_t                 state_reg, state_next;
    logic                   go_reg, go_next;
    logic [MIN_BITS-1:0]    min_len_reg;
    logic                   ref_latched_reg, ref_latched_next;
    logic [WORD_BITS-1:0]   ref_len_reg, ref_len_next;
    logic [DIFF_BITS-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [DIFF_BITS-1:0]   dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic                   dxn_reg, dxn_next, dyn_reg, dyn_next;
    logic                   dvxn_reg, dvxn_next, dvyn_reg, dvyn_next;
    logic [WIDE_BITS-1:0]   sum_reg, sum_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [UNIT_BITS:0]     rx_reg, rx_next, ry_reg, ry_next;
    logic signed [WIDE_BITS-1:0] accr_reg, accr_next, acct_reg, acct_next;
    logic [WORD_BITS-1:0]   vr_reg, vr_next, vt_reg, vt_next;
    logic [WORD_BITS-1:0]   cent_reg, cent_next;
    logic [WORD_BITS:0]     lerr_reg, lerr_next;
    status_t                status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]    out_data_reg, out_data_next;
    logic [1:0]             out_user_reg, out_user_next;

    unit_req_t              unit_req;
    unit_rsp_t              unit_rsp;
    logic [WIDE_BITS-1:0]   unit_a;
    logic [LEN_BITS-1:0]    unit_b;
    logic [WIDE_BITS-1:0]   unit_res;

    logic [DIFF_BITS-1:0]   d_x, d_y, d_vx, d_vy;
    logic [WORD_BITS-1:0]   len_sat;
    logic                   latch_now;
    logic [WORD_BITS-1:0]   ref_new;
    logic signed [WIDE_BITS-1:0] prod_s;
    logic                   prod_neg;
    logic [WORD_BITS-1:0]   rx_word, ry_word, vt_mag;

    function automatic logic [DIFF_BITS-1:0] diff(input logic [WORD_BITS-1:0] a,
                                                  input logic [WORD_BITS-1:0] b);
        diff = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    endfunction

    function automatic logic [DIFF_BITS-1:0] magn(input logic [DIFF_BITS-1:0] d);
        magn = d[DIFF_BITS-1] ? (~d + 1'b1) : d;
    endfunction

    function automatic logic [WORD_BITS-1:0] sat_s(input logic signed [WIDE_BITS-1:0] a);
        logic signed [WIDE_BITS-1:0] sh;
        sh = a >>> UNIT_BITS;
        if (sh > $signed({{(WIDE_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}}))
            sat_s = {1'b0, {(WORD_BITS-1){1'b1}}};
        else if (sh < $signed({{(WIDE_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}}))
            sat_s = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            sat_s = sh[WORD_BITS-1:0];
    endfunction

    rcs_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .opa    (unit_a),
        .opb    (unit_b),
        .rsp    (unit_rsp),
        .result (unit_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            go_reg          <= 1'b0;
            min_len_reg     <= MIN_BITS'(1);
            ref_latched_reg <= 1'b0;
            ref_len_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            go_reg          <= go_next;
            ref_latched_reg <= ref_latched_next;
            ref_len_reg     <= ref_len_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                min_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dvx_reg      <= dvx_next;
        dvy_reg      <= dvy_next;
        dxn_reg      <= dxn_next;
        dyn_reg      <= dyn_next;
        dvxn_reg     <= dvxn_next;
        dvyn_reg     <= dvyn_next;
        sum_reg      <= sum_next;
        len_reg      <= len_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        accr_reg     <= accr_next;
        acct_reg     <= acct_next;
        vr_reg       <= vr_next;
        vt_reg       <= vt_next;
        cent_reg     <= cent_next;
        lerr_reg     <= lerr_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign d_x  = diff(s_tdata[2*WORD_BITS +: WORD_BITS], s_tdata[0 +: WORD_BITS]);
    assign d_y  = diff(s_tdata[3*WORD_BITS +: WORD_BITS], s_tdata[WORD_BITS +: WORD_BITS]);
    assign d_vx = diff(s_tdata[6*WORD_BITS +: WORD_BITS], s_tdata[4*WORD_BITS +: WORD_BITS]);
    assign d_vy = diff(s_tdata[7*WORD_BITS +: WORD_BITS], s_tdata[5*WORD_BITS +: WORD_BITS]);

    assign len_sat   = (len_reg[LEN_BITS-1:WORD_BITS] != '0) ? WMAX : len_reg[WORD_BITS-1:0];
    assign latch_now = !ref_latched_reg && (len_reg > {{(LEN_BITS-MIN_BITS){1'b0}}, min_len_reg});
    assign ref_new   = latch_now ? len_sat : ref_len_reg;
    assign rx_word   = dxn_reg ? (~{1'b0, rx_reg} + 1'b1) : {1'b0, rx_reg};
    assign ry_word   = dyn_reg ? (~{1'b0, ry_reg} + 1'b1) : {1'b0, ry_reg};
    assign vt_mag    = vt_reg[WORD_BITS-1] ? (~vt_reg + 1'b1) : vt_reg;
    assign prod_s    = prod_neg ? -$signed(unit_res) : $signed(unit_res);
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        go_next          = go_reg;
        ref_latched_next = ref_latched_reg;
        ref_len_next     = ref_len_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        dvx_next         = dvx_reg;
        dvy_next         = dvy_reg;
        dxn_next         = dxn_reg;
        dyn_next         = dyn_reg;
        dvxn_next        = dvxn_reg;
        dvyn_next        = dvyn_reg;
        sum_next         = sum_reg;
        len_next         = len_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        accr_next        = accr_reg;
        acct_next        = acct_reg;
        vr_next          = vr_reg;
        vt_next          = vt_reg;
        cent_next        = cent_reg;
        lerr_next        = lerr_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        unit_req.start   = 1'b0;
        unit_req.op      = OP_MUL;
        unit_a           = '0;
        unit_b           = '0;
        prod_neg         = 1'b0;

        unique case (state_reg)
            ST_SQX:
            begin
                unit_a = {{(WIDE_BITS-DIFF_BITS){1'b0}}, dx_reg};
                unit_b = {1'b0, dx_reg};
            end
            ST_SQY:
            begin
                unit_a = {{(WIDE_BITS-DIFF_BITS){1'b0}}, dy_reg};
                unit_b = {1'b0, dy_reg};
            end
            ST_ROOT:
            begin
                unit_req.op = OP_SQRT;
                unit_a      = sum_reg;
            end
            ST_DIVX:
            begin
                unit_req.op = OP_DIV;
                unit_a      = {{(WIDE_BITS-DIFF_BITS-UNIT_BITS){1'b0}}, dx_reg,
                               {UNIT_BITS{1'b0}}};
                unit_b      = len_reg;
            end
            ST_DIVY:
            begin
                unit_req.op = OP_DIV;
                unit_a      = {{(WIDE_BITS-DIFF_BITS-UNIT_BITS){1'b0}}, dy_reg,
                               {UNIT_BITS{1'b0}}};
                unit_b      = len_reg;
            end
            ST_M1:
            begin
                unit_a   = {{(WIDE_BITS-DIFF_BITS){1'b0}}, dvx_reg};
                unit_b   = {{(LEN_BITS-UNIT_BITS-1){1'b0}}, rx_reg};
                prod_neg = dvxn_reg ^ dxn_reg;
            end
            ST_M2:
            begin
                unit_a   = {{(WIDE_BITS-DIFF_BITS){1'b0}}, dvy_reg};
                unit_b   = {{(LEN_BITS-UNIT_BITS-1){1'b0}}, ry_reg};
                prod_neg = dvyn_reg ^ dyn_reg;
            end
            ST_M3:
            begin
                unit_a   = {{(WIDE_BITS-DIFF_BITS){1'b0}}, dvx_reg};
                unit_b   = {{(LEN_BITS-UNIT_BITS-1){1'b0}}, ry_reg};
                prod_neg = ~(dvxn_reg ^ dyn_reg);
            end
            ST_M4:
            begin
                unit_a   = {{(WIDE_BITS-DIFF_BITS){1'b0}}, dvy_reg};
                unit_b   = {{(LEN_BITS-UNIT_BITS-1){1'b0}}, rx_reg};
                prod_neg = dvyn_reg ^ dxn_reg;
            end
            ST_CSQ:
            begin
                unit_a = {{(WIDE_BITS-WORD_BITS){1'b0}}, vt_mag};
                unit_b = {{(LEN_BITS-WORD_BITS){1'b0}}, vt_mag};
            end
            ST_CDIV:
            begin
                unit_req.op = OP_DIV;
                unit_a      = sum_reg;
                unit_b      = len_reg;
            end
            default:
            begin
                unit_a = '0;
            end
        endcase

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dx_next   = magn(d_x);
                    dy_next   = magn(d_y);
                    dvx_next  = magn(d_vx);
                    dvy_next  = magn(d_vy);
                    dxn_next  = d_x[DIFF_BITS-1];
                    dyn_next  = d_y[DIFF_BITS-1];
                    dvxn_next = d_vx[DIFF_BITS-1];
                    dvyn_next = d_vy[DIFF_BITS-1];
                    lerr_next = '0;
                    if (s_tuser)
                    begin
                        status_next = STAT_OK;
                        state_next  = ST_SQX;
                    end
                    else
                    begin
                        status_next = STAT_INVALID;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_CHECK:
            begin
                ref_latched_next = ref_latched_reg || latch_now;
                ref_len_next     = ref_new;
                if (ref_latched_reg || latch_now)
                begin
                    lerr_next = {1'b0, len_sat} - {1'b0, ref_new};
                end
                if (len_reg <= {{(LEN_BITS-MIN_BITS){1'b0}}, min_len_reg})
                begin
                    status_next = STAT_SHORT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIVX;
                end
            end
            ST_SAT:
            begin
                vr_next    = sat_s(accr_reg);
                vt_next    = sat_s(acct_reg);
                state_next = ST_CSQ;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = status_reg;
                    out_data_next  = '0;
                    out_data_next[6*WORD_BITS +: WORD_BITS+1] = lerr_reg;
                    if (status_reg == STAT_OK)
                    begin
                        out_data_next[0 +: WORD_BITS]           = len_sat;
                        out_data_next[WORD_BITS +: WORD_BITS]   = rx_word;
                        out_data_next[2*WORD_BITS +: WORD_BITS] = ry_word;
                        out_data_next[3*WORD_BITS +: WORD_BITS] = vr_reg;
                        out_data_next[4*WORD_BITS +: WORD_BITS] = vt_reg;
                        out_data_next[5*WORD_BITS +: WORD_BITS] = cent_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                if (!go_reg)
                begin
                    unit_req.start = 1'b1;
                    go_next        = 1'b1;
                end
                else if (unit_rsp.done)
                begin
                    go_next = 1'b0;
                    unique case (state_reg)
                        ST_SQX:
                        begin
                            sum_next   = unit_res;
                            state_next = ST_SQY;
                        end
                        ST_SQY:
                        begin
                            sum_next   = sum_reg + unit_res;
                            state_next = ST_ROOT;
                        end
                        ST_ROOT:
                        begin
                            len_next   = unit_res[LEN_BITS-1:0];
                            state_next = ST_CHECK;
                        end
                        ST_DIVX:
                        begin
                            rx_next    = unit_res[UNIT_BITS:0];
                            state_next = ST_DIVY;
                        end
                        ST_DIVY:
                        begin
                            ry_next    = unit_res[UNIT_BITS:0];
                            state_next = ST_M1;
                        end
                        ST_M1:
                        begin
                            accr_next  = prod_s;
                            state_next = ST_M2;
                        end
                        ST_M2:
                        begin
                            accr_next  = accr_reg + prod_s;
                            state_next = ST_M3;
                        end
                        ST_M3:
                        begin
                            acct_next  = prod_s;
                            state_next = ST_M4;
                        end
                        ST_M4:
                        begin
                            acct_next  = acct_reg + prod_s;
                            state_next = ST_SAT;
                        end
                        ST_CSQ:
                        begin
                            sum_next   = unit_res;
                            state_next = ST_CDIV;
                        end
                        ST_CDIV:
                        begin
                            cent_next  = (unit_res[WIDE_BITS-1:WORD_BITS] != '0) ? WMAX
                                         : unit_res[WORD_BITS-1:0];
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted transfer did not start work");

    a_latch_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        ref_latched_reg |=> ref_latched_reg)
        else $error("reference latch was lost");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata[6*WORD_BITS-1:0] == '0))
        else $error("non-ok result carries data");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        unit_req.start |-> !unit_rsp.busy)
        else $error("serial unit started while busy");

endmodule

// ===== verif/tb_rod_constraint_state_top.sv =====
// Self-checking testbench for the rod constraint state block with random stimulus and stalls.
`timescale 1ns / 1ps
module tb_rod_constraint_state_top;
    import rcs_pkg::*;

    typedef struct {
        logic       pair_ok;
        logic [31:0] px, py, bx, by, pvx, pvy, bvx, bvy;
    } rod_item_t;

    typedef struct {
        status_t     status;
        logic [31:0] length;
        logic [31:0] rad_x, rad_y, v_rad, v_tan, cent;
        logic [32:0] len_err;
    } rod_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [MIN_BITS-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic [1:0] m_tuser;

    rod_item_t  pending_items[$];
    rod_item_t  cur_item;
    rod_state_t expected_states[$];
    logic [15:0] min_len_q = 16'd1;
    logic [31:0] ref_len_q = '0;
    logic        ref_latched_q = 1'b0;
    int  error_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_off = 0;
    int  stall_phase = 0;
    logic sending = 1'b0;

    rod_constraint_state_top uut (.*);

    always #10 clk = ~clk;

    function automatic logic [63:0] isqrt_u128(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] sat_signed32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 128'sd2147483647;
        if (v < -128'sd2147483648)
            return -128'sd2147483648;
        return v;
    endfunction

    function automatic rod_state_t predict_rod(rod_item_t it);
        rod_state_t r;
        logic signed [63:0] dx, dy, dvx, dvy, rx, ry;
        logic [63:0] len, len_sat;
        logic [127:0] sq, tan_sq;
        logic signed [127:0] vr, vt;
        r = '{STAT_OK, '0, '0, '0, '0, '0, '0, '0};
        if (!it.pair_ok)
        begin
            r.status = STAT_INVALID;
            return r;
        end
        dx  = $signed(it.bx)  - $signed(it.px);
        dy  = $signed(it.by)  - $signed(it.py);
        dvx = $signed(it.bvx) - $signed(it.pvx);
        dvy = $signed(it.bvy) - $signed(it.pvy);
        sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        len = isqrt_u128(sq);
        len_sat = (len > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : len;
        if (!ref_latched_q && len > {48'd0, min_len_q})
        begin
            ref_len_q = len_sat[31:0];
            ref_latched_q = 1'b1;
        end
        if (ref_latched_q)
            r.len_err = 33'({1'b0, len_sat[31:0]} - {1'b0, ref_len_q});
        if (len <= {48'd0, min_len_q})
        begin
            r.status = STAT_SHORT;
            return r;
        end
        rx = (dx < 0) ? -$signed(64'((128'(-dx) << 30) / len))
                      : $signed(64'((128'(dx) << 30) / len));
        ry = (dy < 0) ? -$signed(64'((128'(-dy) << 30) / len))
                      : $signed(64'((128'(dy) << 30) / len));
        vr = sat_signed32((128'(dvx) * 128'(rx) + 128'(dvy) * 128'(ry)) >>> 30);
        vt = sat_signed32((128'(dvy) * 128'(rx) - 128'(dvx) * 128'(ry)) >>> 30);
        tan_sq = (vt * vt) / len;
        r.length = len_sat[31:0];
        r.rad_x = rx[31:0];
        r.rad_y = ry[31:0];
        r.v_rad = vr[31:0];
        r.v_tan = vt[31:0];
        r.cent = (tan_sq > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : tan_sq[31:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 8) << 16;
            3: return $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic rod_item_t random_rod();
        rod_item_t it;
        logic [31:0] base;
        it.pair_ok = ($urandom_range(0, 9) != 0);
        it.px = pick_word();
        it.py = pick_word();
        it.pvx = pick_word();
        it.pvy = pick_word();
        it.bvx = pick_word();
        it.bvy = pick_word();
        if ($urandom_range(0, 2) == 0)
        begin
            it.bx = pick_word();
            it.by = pick_word();
        end
        else
        begin
            base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 32'h40000);
            it.bx = it.px + ($urandom_range(0, 1) ? base : -base);
            it.by = it.py + $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
        end
        return it;
    endfunction

    task automatic add_rod(logic ok, logic [31:0] px, py, bx, by, pvx, pvy, bvx, bvy);
        pending_items.push_back('{ok, px, py, bx, by, pvx, pvy, bvx, bvy});
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || sending || expected_states.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_min_len(logic [15:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_len_q = v;
    endtask

    always @(posedge clk)
    begin
        if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
                sending <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                cur_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                sending <= 1'b1;
                s_tuser <= cur_item.pair_ok;
                s_tdata <= {cur_item.bvy, cur_item.bvx, cur_item.pvy, cur_item.pvx,
                            cur_item.by, cur_item.bx, cur_item.py, cur_item.px};
                expected_states.push_back(predict_rod(cur_item));
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
                sending <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (stall_phase % 3000 == 2999)
        begin
            hold_off <= 4000;
            m_tready <= 1'b0;
        end
        else if ((stall_phase / 500) % 2 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        rod_state_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_states.size() == 0)
            begin
                error_count <= error_count + 1;
                if (error_count < 10)
                    $display("Unexpected transfer: tuser=%0d", m_tuser);
            end
            else
            begin
                e = expected_states.pop_front();
                if (m_tuser != e.status || m_tdata[31:0] != e.length
                    || m_tdata[63:32] != e.rad_x || m_tdata[95:64] != e.rad_y
                    || m_tdata[127:96] != e.v_rad || m_tdata[159:128] != e.v_tan
                    || m_tdata[191:160] != e.cent || m_tdata[224:192] != e.len_err)
                begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("Mismatch: exp st=%0d len=%h rx=%h ry=%h vr=%h vt=%h c=%h le=%h got st=%0d len=%h rx=%h ry=%h vr=%h vt=%h c=%h le=%h",
                            e.status, e.length, e.rad_x, e.rad_y, e.v_rad, e.v_tan, e.cent,
                            e.len_err, m_tuser, m_tdata[31:0], m_tdata[63:32],
                            m_tdata[95:64], m_tdata[127:96], m_tdata[159:128],
                            m_tdata[191:160], m_tdata[224:192]);
                end
            end
        end
    end

    initial
    begin
        #300ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        add_rod(1'b0, '1, '1, '1, '1, '1, '1, '1, '1);
        add_rod(1'b1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_rod(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5, 32'd5, 32'd5, 32'd5);
        add_rod(1'b1, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000);
        add_rod(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_rod(1'b1, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_rod(1'b1, 32'd0, 32'd0, 32'd0, 32'h0000_8000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0);
        add_rod(1'b1, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_rod(1'b0, 32'd0, 32'd0, 32'd9, 32'd9, 32'd0, 32'd0, 32'd0, 32'd0);
        add_rod(1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h0003_0000, 32'hFFFD_0000,
                32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'd1);
        wait_drained();
        write_min_len(16'hFFFF);
        for (int i = 0; i < 400; i++)
            pending_items.push_back(random_rod());
        wait_drained();
        write_min_len(16'd0);
        for (int i = 0; i < 450; i++)
            pending_items.push_back(random_rod());
        wait_drained();
        write_min_len(16'h8000);
        for (int i = 0; i < 450; i++)
            pending_items.push_back(random_rod());
        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
src/rcs_pkg.sv
src/rcs_serial_unit.sv
src/rod_constraint_state_top.sv
verif/tb_rod_constraint_state_top.sv
